FILE: design/rtc_pkg.sv
// Shared widths, pipeline constants and register indexes for the rigid transform composer.
package rtc_pkg;

    localparam int ROT_W           = 16;
    localparam int SHIFT_W         = 32;
    localparam int ROT_FRAC_BITS   = 14;
    localparam int SHIFT_FRAC_BITS = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = SHIFT_W;
    localparam int PIPE_DEPTH      = 4;
    localparam int DEPTH_CNT_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PARENT_ROT_X   = 3'd0,
        REG_PARENT_ROT_Y   = 3'd1,
        REG_PARENT_ROT_Z   = 3'd2,
        REG_PARENT_ROT_W   = 3'd3,
        REG_PARENT_SHIFT_X = 3'd4,
        REG_PARENT_SHIFT_Y = 3'd5,
        REG_PARENT_SHIFT_Z = 3'd6
    } t_reg_idx;

    localparam logic signed [ROT_W-1:0] ROT_W_RESET = 16'sd16384;

endpackage

FILE: design/rtc_if.sv
// Stream and configuration interfaces for the rigid transform composer.
interface rtc_child_if;
    import rtc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ROT_W-1:0]   child_rot_x;
    logic signed [ROT_W-1:0]   child_rot_y;
    logic signed [ROT_W-1:0]   child_rot_z;
    logic signed [ROT_W-1:0]   child_rot_w;
    logic signed [SHIFT_W-1:0] child_shift_x;
    logic signed [SHIFT_W-1:0] child_shift_y;
    logic signed [SHIFT_W-1:0] child_shift_z;

    modport source (
        output valid, child_rot_x, child_rot_y, child_rot_z, child_rot_w,
               child_shift_x, child_shift_y, child_shift_z,
        input  ready
    );
    modport sink (
        input  valid, child_rot_x, child_rot_y, child_rot_z, child_rot_w,
               child_shift_x, child_shift_y, child_shift_z,
        output ready
    );
endinterface

interface rtc_result_if;
    import rtc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ROT_W-1:0]   out_rot_x;
    logic signed [ROT_W-1:0]   out_rot_y;
    logic signed [ROT_W-1:0]   out_rot_z;
    logic signed [ROT_W-1:0]   out_rot_w;
    logic signed [SHIFT_W-1:0] out_shift_x;
    logic signed [SHIFT_W-1:0] out_shift_y;
    logic signed [SHIFT_W-1:0] out_shift_z;

    modport source (
        output valid, out_rot_x, out_rot_y, out_rot_z, out_rot_w,
               out_shift_x, out_shift_y, out_shift_z,
        input  ready
    );
    modport sink (
        input  valid, out_rot_x, out_rot_y, out_rot_z, out_rot_w,
               out_shift_x, out_shift_y, out_shift_z,
        output ready
    );
endinterface

interface rtc_cfg_if;
    import rtc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/rigid_transform_compose_top.sv
// Top level of the rigid transform composer: four-stage pipeline, parent held in registers.
// Accepts one child transaction per cycle unless the output stalls, and returns one result per
// child, in order. A result is held in the last stage until the output takes it. The four
// register stages are: parent and child products; quaternion sums and rounded rotation matrix;
// matrix times child translation; row sums, rounding, parent translation and saturation. Each
// stage holds its transaction while the stage after it is full and stalled, so the pipeline
// keeps up to four transactions. Configuration writes are always accepted.
module rigid_transform_compose_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rtc_child_if.sink    i_child,
    rtc_result_if.source o_result,
    rtc_cfg_if.sink      i_cfg
);
    import rtc_pkg::*;

    localparam int PROD_W  = 2 * ROT_W;
    localparam int QSUM_W  = PROD_W + 2;
    localparam int QR_W    = QSUM_W + 1;
    localparam int MSUM_W  = PROD_W + 3;
    localparam int MR_W    = MSUM_W + 1;
    localparam int MENT_W  = MSUM_W + 1 - ROT_FRAC_BITS;
    localparam int TP_W    = SHIFT_W + MENT_W;
    localparam int ACC_W   = TP_W + 2;
    localparam int AR_W    = ACC_W + 2;

    localparam logic signed [QR_W-1:0] Q_HALF = {{(QR_W-1){1'b0}}, 1'b1} << (ROT_FRAC_BITS-1);
    localparam logic signed [MR_W-1:0] M_HALF = {{(MR_W-1){1'b0}}, 1'b1} << (ROT_FRAC_BITS-1);
    localparam logic signed [AR_W-1:0] A_HALF = {{(AR_W-1){1'b0}}, 1'b1} << (ROT_FRAC_BITS-1);
    localparam logic signed [QR_W-1:0] Q_MAX  = {{(QR_W-ROT_W+1){1'b0}}, {(ROT_W-1){1'b1}}};
    localparam logic signed [QR_W-1:0] Q_MIN  = {{(QR_W-ROT_W+1){1'b1}}, {(ROT_W-1){1'b0}}};
    localparam logic signed [AR_W-1:0] S_MAX  = {{(AR_W-SHIFT_W+1){1'b0}}, {(SHIFT_W-1){1'b1}}};
    localparam logic signed [AR_W-1:0] S_MIN  = {{(AR_W-SHIFT_W+1){1'b1}}, {(SHIFT_W-1){1'b0}}};

    function automatic logic signed [ROT_W-1:0] sat_rot(input logic signed [QR_W-1:0] a);
        logic signed [ROT_W-1:0] res;
        if (a > Q_MAX) begin
            res = Q_MAX[ROT_W-1:0];
        end else if (a < Q_MIN) begin
            res = Q_MIN[ROT_W-1:0];
        end else begin
            res = a[ROT_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [SHIFT_W-1:0] sat_shift(input logic signed [AR_W-1:0] a);
        logic signed [SHIFT_W-1:0] res;
        if (a > S_MAX) begin
            res = S_MAX[SHIFT_W-1:0];
        end else if (a < S_MIN) begin
            res = S_MIN[SHIFT_W-1:0];
        end else begin
            res = a[SHIFT_W-1:0];
        end
        return res;
    endfunction

    // Configuration registers: quaternion x, y, z, w and translation x, y, z.
    logic signed [ROT_W-1:0]   r_p_rot [4];
    logic signed [SHIFT_W-1:0] r_p_shift [3];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_rot[0]   <= '0;
            r_p_rot[1]   <= '0;
            r_p_rot[2]   <= '0;
            r_p_rot[3]   <= ROT_W_RESET;
            r_p_shift[0] <= '0;
            r_p_shift[1] <= '0;
            r_p_shift[2] <= '0;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_PARENT_ROT_X:   r_p_rot[0]   <= i_cfg.data[ROT_W-1:0];
                REG_PARENT_ROT_Y:   r_p_rot[1]   <= i_cfg.data[ROT_W-1:0];
                REG_PARENT_ROT_Z:   r_p_rot[2]   <= i_cfg.data[ROT_W-1:0];
                REG_PARENT_ROT_W:   r_p_rot[3]   <= i_cfg.data[ROT_W-1:0];
                REG_PARENT_SHIFT_X: r_p_shift[0] <= i_cfg.data[SHIFT_W-1:0];
                REG_PARENT_SHIFT_Y: r_p_shift[1] <= i_cfg.data[SHIFT_W-1:0];
                REG_PARENT_SHIFT_Z: r_p_shift[2] <= i_cfg.data[SHIFT_W-1:0];
                default: ; // drop writes past the last register
            endcase
        end
    end

    // Stage handshake: a stage advances when empty or when the next one advances.
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    assign en4 = !r_v4 || o_result.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_child.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_child.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Stage 1: all 16x16 products.
    logic signed [PROD_W-1:0]  r1_qp [16];
    logic signed [PROD_W-1:0]  n1_qp [16];
    logic signed [PROD_W-1:0]  r1_pp [10];
    logic signed [PROD_W-1:0]  n1_pp [10];
    logic signed [SHIFT_W-1:0] r1_v [3];

    always_comb begin
        logic signed [ROT_W-1:0] px, py, pz, pw, cx, cy, cz, cw;
        px = r_p_rot[0];
        py = r_p_rot[1];
        pz = r_p_rot[2];
        pw = r_p_rot[3];
        cx = i_child.child_rot_x;
        cy = i_child.child_rot_y;
        cz = i_child.child_rot_z;
        cw = i_child.child_rot_w;
        n1_qp[0]  = pw * cw;
        n1_qp[1]  = px * cx;
        n1_qp[2]  = py * cy;
        n1_qp[3]  = pz * cz;
        n1_qp[4]  = pw * cx;
        n1_qp[5]  = px * cw;
        n1_qp[6]  = py * cz;
        n1_qp[7]  = pz * cy;
        n1_qp[8]  = pw * cy;
        n1_qp[9]  = px * cz;
        n1_qp[10] = py * cw;
        n1_qp[11] = pz * cx;
        n1_qp[12] = pw * cz;
        n1_qp[13] = px * cy;
        n1_qp[14] = py * cx;
        n1_qp[15] = pz * cw;
        // xx yy zz ww xy xz xw yz yw zw
        n1_pp[0]  = px * px;
        n1_pp[1]  = py * py;
        n1_pp[2]  = pz * pz;
        n1_pp[3]  = pw * pw;
        n1_pp[4]  = px * py;
        n1_pp[5]  = px * pz;
        n1_pp[6]  = px * pw;
        n1_pp[7]  = py * pz;
        n1_pp[8]  = py * pw;
        n1_pp[9]  = pz * pw;
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_qp   <= n1_qp;
            r1_pp   <= n1_pp;
            r1_v[0] <= i_child.child_shift_x;
            r1_v[1] <= i_child.child_shift_y;
            r1_v[2] <= i_child.child_shift_z;
        end
    end

    // Stage 2: quaternion sums with rounding and saturation, rounded matrix entries.
    logic signed [ROT_W-1:0]   r2_rot [4];
    logic signed [ROT_W-1:0]   n2_rot [4];
    logic signed [MENT_W-1:0]  r2_m [9];
    logic signed [MENT_W-1:0]  n2_m [9];
    logic signed [SHIFT_W-1:0] r2_v [3];

    always_comb begin
        logic signed [QR_W-1:0]   q [16];
        logic signed [QR_W-1:0]   qs [4];
        logic signed [MR_W-1:0]   e [10];
        logic signed [MR_W-1:0]   ms [9];
        logic signed [MR_W-1:0]   mr;
        for (int k = 0; k < 16; k++) begin
            q[k] = r1_qp[k];
        end
        for (int k = 0; k < 10; k++) begin
            e[k] = r1_pp[k];
        end
        qs[0] = q[4]  + q[5]  + q[6]  - q[7];
        qs[1] = q[8]  - q[9]  + q[10] + q[11];
        qs[2] = q[12] + q[13] - q[14] + q[15];
        qs[3] = q[0]  - q[1]  - q[2]  - q[3];
        for (int k = 0; k < 4; k++) begin
            n2_rot[k] = sat_rot((qs[k] + Q_HALF) >>> ROT_FRAC_BITS);
        end
        ms[0] =  e[0] - e[1] - e[2] + e[3];
        ms[1] = (e[4] <<< 1) - (e[9] <<< 1);
        ms[2] = (e[5] <<< 1) + (e[8] <<< 1);
        ms[3] = (e[4] <<< 1) + (e[9] <<< 1);
        ms[4] = -e[0] + e[1] - e[2] + e[3];
        ms[5] = (e[7] <<< 1) - (e[6] <<< 1);
        ms[6] = (e[5] <<< 1) - (e[8] <<< 1);
        ms[7] = (e[6] <<< 1) + (e[7] <<< 1);
        ms[8] = -e[0] - e[1] + e[2] + e[3];
        for (int k = 0; k < 9; k++) begin
            mr      = (ms[k] + M_HALF) >>> ROT_FRAC_BITS;
            n2_m[k] = mr[MENT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_rot <= n2_rot;
            r2_m   <= n2_m;
            r2_v   <= r1_v;
        end
    end

    // Stage 3: matrix times child translation.
    logic signed [TP_W-1:0]  r3_tp [9];
    logic signed [TP_W-1:0]  n3_tp [9];
    logic signed [ROT_W-1:0] r3_rot [4];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n3_tp[k] = r2_v[k % 3] * r2_m[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_tp  <= n3_tp;
            r3_rot <= r2_rot;
        end
    end

    // Stage 4: row sums, rounding, parent translation, saturation.
    logic signed [SHIFT_W-1:0] r4_shift [3];
    logic signed [SHIFT_W-1:0] n4_shift [3];
    logic signed [ROT_W-1:0]   r4_rot [4];

    always_comb begin
        logic signed [AR_W-1:0] acc;
        logic signed [AR_W-1:0] t;
        logic signed [AR_W-1:0] p;
        for (int r = 0; r < 3; r++) begin
            acc = r3_tp[r*3];
            acc = acc + r3_tp[r*3+1] + r3_tp[r*3+2];
            t   = (acc + A_HALF) >>> ROT_FRAC_BITS;
            p   = r_p_shift[r];
            n4_shift[r] = sat_shift(t + p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_shift <= n4_shift;
            r4_rot   <= r3_rot;
        end
    end

    assign o_result.valid       = r_v4;
    assign o_result.out_rot_x   = r4_rot[0];
    assign o_result.out_rot_y   = r4_rot[1];
    assign o_result.out_rot_z   = r4_rot[2];
    assign o_result.out_rot_w   = r4_rot[3];
    assign o_result.out_shift_x = r4_shift[0];
    assign o_result.out_shift_y = r4_shift[1];
    assign o_result.out_shift_z = r4_shift[2];

endmodule

FILE: design/rtc_checker.sv
// Port-level assertions for the rigid transform composer and their bind.
module rtc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [4*rtc_pkg::ROT_W+3*rtc_pkg::SHIFT_W-1:0] i_out_data
);
    import rtc_pkg::*;

    logic [DEPTH_CNT_W-1:0] r_cnt;
    logic                   in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Track transactions accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + DEPTH_CNT_W'(1);
        end else if (!in_acc && out_acc) begin
            r_cnt <= r_cnt - DEPTH_CNT_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result payload changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("result without an accepted input");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_CNT_W'(PIPE_DEPTH))
        else $error("more transactions in flight than pipeline stages");

endmodule

bind rigid_transform_compose_top rtc_checker u_rtc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_child.valid),
    .i_in_ready  (i_child.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  ({o_result.out_rot_x, o_result.out_rot_y, o_result.out_rot_z,
                   o_result.out_rot_w, o_result.out_shift_x, o_result.out_shift_y,
                   o_result.out_shift_z})
);

FILE: tb/sv/tb_rigid_transform_compose_top.sv
// Self-checking testbench for the rigid transform composer: random stalls, parent sweeps.
module tb_rigid_transform_compose_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rtc_pkg::*;

    localparam int     RESET_CYCLES    = 8;
    localparam int     IDLE_MAX        = 17;
    localparam int     RANDOM_PHASES   = 8;
    localparam int     ITEMS_PER_PHASE = 112;
    localparam int     DRAIN_CYCLES    = 4 * PIPE_DEPTH;
    localparam int     WATCHDOG_LIMIT  = 2000;
    localparam int     MAX_REPORTS     = 100;
    localparam longint ROT_HI          = (longint'(1) << (ROT_W - 1)) - 1;
    localparam longint ROT_LO          = -ROT_HI - 1;
    localparam longint SHIFT_HI        = (longint'(1) << (SHIFT_W - 1)) - 1;
    localparam longint SHIFT_LO        = -SHIFT_HI - 1;
    localparam longint ROT_ONE         = longint'(1) << ROT_FRAC_BITS;
    localparam longint ROT_HALF        = ROT_ONE / 2;
    localparam longint SHIFT_ONE       = longint'(1) << SHIFT_FRAC_BITS;
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd7;

    typedef struct {
        logic signed [ROT_W-1:0]   rot_x;
        logic signed [ROT_W-1:0]   rot_y;
        logic signed [ROT_W-1:0]   rot_z;
        logic signed [ROT_W-1:0]   rot_w;
        logic signed [SHIFT_W-1:0] shift_x;
        logic signed [SHIFT_W-1:0] shift_y;
        logic signed [SHIFT_W-1:0] shift_z;
    } t_rigid_pose;

    logic i_clk;
    logic i_rst_n;

    rtc_child_if  child_bus ();
    rtc_result_if result_bus ();
    rtc_cfg_if    cfg_bus ();

    rigid_transform_compose_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_child  (child_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    // Parent transform as the block should hold it.
    logic signed [ROT_W-1:0]   parent_rot_x   = '0;
    logic signed [ROT_W-1:0]   parent_rot_y   = '0;
    logic signed [ROT_W-1:0]   parent_rot_z   = '0;
    logic signed [ROT_W-1:0]   parent_rot_w   = ROT_W_RESET;
    logic signed [SHIFT_W-1:0] parent_shift_x = '0;
    logic signed [SHIFT_W-1:0] parent_shift_y = '0;
    logic signed [SHIFT_W-1:0] parent_shift_z = '0;

    t_rigid_pose pending_children [$];
    t_rigid_pose expected_poses [$];
    t_rigid_pose child_on_bus;

    int children_queued   = 0;
    int children_accepted = 0;
    int results_seen      = 0;
    int mismatches        = 0;
    int child_idle_max    = 0;
    int result_idle_max   = 0;
    int child_gap         = 0;
    int result_stall      = 0;
    int quiet_cycles      = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint round_rot(longint value);
        return (value + (longint'(1) <<< (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
    endfunction

    function automatic logic signed [ROT_W-1:0] sat_rot(longint value);
        if (value > ROT_HI) value = ROT_HI;
        else if (value < ROT_LO) value = ROT_LO;
        return value[ROT_W-1:0];
    endfunction

    function automatic logic signed [SHIFT_W-1:0] sat_shift(longint value);
        if (value > SHIFT_HI) value = SHIFT_HI;
        else if (value < SHIFT_LO) value = SHIFT_LO;
        return value[SHIFT_W-1:0];
    endfunction

    // Parent * child: Hamilton product for the rotation, parent rotation applied
    // to the child translation through the unnormalized matrix.
    function automatic t_rigid_pose compose_transform(t_rigid_pose child);
        longint px, py, pz, pw, cx, cy, cz, cw, vx, vy, vz;
        longint xx, yy, zz, ww, sxy, sxz, sxw, syz, syw, szw;
        longint rot_m [9];
        longint moved [3];
        t_rigid_pose pose;
        px = parent_rot_x;
        py = parent_rot_y;
        pz = parent_rot_z;
        pw = parent_rot_w;
        cx = child.rot_x;
        cy = child.rot_y;
        cz = child.rot_z;
        cw = child.rot_w;
        vx = child.shift_x;
        vy = child.shift_y;
        vz = child.shift_z;

        pose.rot_w = sat_rot(round_rot(pw * cw - px * cx - py * cy - pz * cz));
        pose.rot_x = sat_rot(round_rot(pw * cx + px * cw + py * cz - pz * cy));
        pose.rot_y = sat_rot(round_rot(pw * cy - px * cz + py * cw + pz * cx));
        pose.rot_z = sat_rot(round_rot(pw * cz + px * cy - py * cx + pz * cw));

        xx  = px * px;
        yy  = py * py;
        zz  = pz * pz;
        ww  = pw * pw;
        sxy = 2 * px * py;
        sxz = 2 * px * pz;
        sxw = 2 * px * pw;
        syz = 2 * py * pz;
        syw = 2 * py * pw;
        szw = 2 * pz * pw;

        rot_m[0] = round_rot(xx - yy - zz + ww);
        rot_m[1] = round_rot(sxy - szw);
        rot_m[2] = round_rot(sxz + syw);
        rot_m[3] = round_rot(sxy + szw);
        rot_m[4] = round_rot(-xx + yy - zz + ww);
        rot_m[5] = round_rot(-sxw + syz);
        rot_m[6] = round_rot(sxz - syw);
        rot_m[7] = round_rot(sxw + syz);
        rot_m[8] = round_rot(-xx - yy + zz + ww);

        for (int row = 0; row < 3; row++) begin
            moved[row] = round_rot(vx * rot_m[3 * row] + vy * rot_m[3 * row + 1]
                                   + vz * rot_m[3 * row + 2]);
        end
        pose.shift_x = sat_shift(parent_shift_x + moved[0]);
        pose.shift_y = sat_shift(parent_shift_y + moved[1]);
        pose.shift_z = sat_shift(parent_shift_z + moved[2]);
        return pose;
    endfunction

    function automatic t_rigid_pose make_pose(longint rx, longint ry, longint rz, longint rw,
                                              longint sx, longint sy, longint sz);
        t_rigid_pose pose;
        pose.rot_x   = rx[ROT_W-1:0];
        pose.rot_y   = ry[ROT_W-1:0];
        pose.rot_z   = rz[ROT_W-1:0];
        pose.rot_w   = rw[ROT_W-1:0];
        pose.shift_x = sx[SHIFT_W-1:0];
        pose.shift_y = sy[SHIFT_W-1:0];
        pose.shift_z = sz[SHIFT_W-1:0];
        return pose;
    endfunction

    function automatic longint extreme_rot();
        case ($urandom_range(0, 4))
            0:       return ROT_HI;
            1:       return ROT_LO;
            2:       return 0;
            3:       return -1;
            default: return ROT_ONE;
        endcase
    endfunction

    function automatic longint extreme_shift();
        case ($urandom_range(0, 4))
            0:       return SHIFT_HI;
            1:       return SHIFT_LO;
            2:       return 0;
            3:       return -1;
            default: return SHIFT_ONE;
        endcase
    endfunction

    function automatic t_rigid_pose random_child();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                return make_pose($urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
            6, 7:
                return make_pose($urandom_range(0, 32768) - 16384,
                                 $urandom_range(0, 32768) - 16384,
                                 $urandom_range(0, 32768) - 16384,
                                 $urandom_range(0, 32768) - 16384,
                                 $urandom_range(0, 1 << 25) - (1 << 24),
                                 $urandom_range(0, 1 << 25) - (1 << 24),
                                 $urandom_range(0, 1 << 25) - (1 << 24));
            8:
                return make_pose(extreme_rot(), extreme_rot(), extreme_rot(), extreme_rot(),
                                 extreme_shift(), extreme_shift(), extreme_shift());
            default:
                return make_pose($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32,
                                 $urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32,
                                 $urandom_range(0, 1 << 18) - (1 << 17),
                                 $urandom_range(0, 1 << 18) - (1 << 17),
                                 $urandom_range(0, 1 << 18) - (1 << 17));
        endcase
    endfunction

    // Rotation registers are 16 bits wide; fill the unused data bits with noise.
    function automatic logic [CFG_DATA_W-1:0] rot_word(longint value);
        logic [CFG_DATA_W-1:0] word;
        word = $urandom;
        word[ROT_W-1:0] = value[ROT_W-1:0];
        return word;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            REG_PARENT_ROT_X:   parent_rot_x   = data[ROT_W-1:0];
            REG_PARENT_ROT_Y:   parent_rot_y   = data[ROT_W-1:0];
            REG_PARENT_ROT_Z:   parent_rot_z   = data[ROT_W-1:0];
            REG_PARENT_ROT_W:   parent_rot_w   = data[ROT_W-1:0];
            REG_PARENT_SHIFT_X: parent_shift_x = data[SHIFT_W-1:0];
            REG_PARENT_SHIFT_Y: parent_shift_y = data[SHIFT_W-1:0];
            REG_PARENT_SHIFT_Z: parent_shift_z = data[SHIFT_W-1:0];
            default: ;  // no such register: drop the write
        endcase
    endtask

    task automatic write_parent_set(input longint rx, input longint ry, input longint rz,
                                    input longint rw, input longint sx, input longint sy,
                                    input longint sz);
        write_register(REG_PARENT_ROT_X, rot_word(rx));
        write_register(REG_PARENT_ROT_Y, rot_word(ry));
        write_register(REG_PARENT_ROT_Z, rot_word(rz));
        write_register(REG_PARENT_ROT_W, rot_word(rw));
        write_register(REG_PARENT_SHIFT_X, sx[SHIFT_W-1:0]);
        write_register(REG_PARENT_SHIFT_Y, sy[SHIFT_W-1:0]);
        write_register(REG_PARENT_SHIFT_Z, sz[SHIFT_W-1:0]);
        if ($urandom_range(0, 2) == 0) write_register(UNUSED_REG_IDX, $urandom);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic randomize_parent();
        longint rx, ry, rz, rw, sx, sy, sz;
        case ($urandom_range(0, 4))
            0: begin
                rx = $urandom; ry = $urandom; rz = $urandom; rw = $urandom;
                sx = $urandom; sy = $urandom; sz = $urandom;
            end
            1: begin
                // unit quaternion: every component is +-0.5
                rx = $urandom_range(0, 1) ? ROT_HALF : -ROT_HALF;
                ry = $urandom_range(0, 1) ? ROT_HALF : -ROT_HALF;
                rz = $urandom_range(0, 1) ? ROT_HALF : -ROT_HALF;
                rw = $urandom_range(0, 1) ? ROT_HALF : -ROT_HALF;
                sx = $urandom_range(0, 1 << 25) - (1 << 24);
                sy = $urandom_range(0, 1 << 25) - (1 << 24);
                sz = $urandom_range(0, 1 << 25) - (1 << 24);
            end
            2: begin
                rx = extreme_rot(); ry = extreme_rot(); rz = extreme_rot(); rw = extreme_rot();
                sx = extreme_shift(); sy = extreme_shift(); sz = extreme_shift();
            end
            3: begin
                rx = $urandom_range(0, 40000) - 20000;
                ry = $urandom_range(0, 40000) - 20000;
                rz = $urandom_range(0, 40000) - 20000;
                rw = $urandom_range(0, 40000) - 20000;
                sx = $urandom; sy = $urandom; sz = $urandom;
            end
            default: begin
                // translation near extreme values, the rails among them, to provoke saturation
                rx = $urandom; ry = $urandom; rz = $urandom; rw = $urandom;
                sx = extreme_shift() + $urandom_range(0, 255) - 128;
                sy = extreme_shift() + $urandom_range(0, 255) - 128;
                sz = extreme_shift() + $urandom_range(0, 255) - 128;
            end
        endcase
        write_parent_set(rx, ry, rz, rw, sx, sy, sz);
    endtask

    task automatic queue_child(input t_rigid_pose child);
        pending_children.push_back(child);
        children_queued++;
    endtask

    // Extra results also end the wait; they are counted as mismatches.
    task automatic wait_until_drained();
        while (children_accepted < children_queued || results_seen < children_queued)
            @(posedge i_clk);
    endtask

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
        end
    endtask

    // Child driver: one transaction per queue entry, random gap after each.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            child_bus.valid <= 1'b0;
            child_gap = 0;
        end else begin
            if (child_bus.valid && child_bus.ready) begin
                expected_poses.push_back(compose_transform(child_on_bus));
                children_accepted++;
            end
            if (!child_bus.valid || child_bus.ready) begin
                if (child_gap > 0) begin
                    child_gap--;
                    child_bus.valid <= 1'b0;
                end else if (pending_children.size() > 0) begin
                    child_on_bus = pending_children.pop_front();
                    child_bus.child_rot_x   <= child_on_bus.rot_x;
                    child_bus.child_rot_y   <= child_on_bus.rot_y;
                    child_bus.child_rot_z   <= child_on_bus.rot_z;
                    child_bus.child_rot_w   <= child_on_bus.rot_w;
                    child_bus.child_shift_x <= child_on_bus.shift_x;
                    child_bus.child_shift_y <= child_on_bus.shift_y;
                    child_bus.child_shift_z <= child_on_bus.shift_z;
                    child_bus.valid         <= 1'b1;
                    child_gap = $urandom_range(0, child_idle_max);
                end else begin
                    child_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each transaction against the oldest prediction, then draw a random stall, possibly none.
    always @(posedge i_clk) begin
        t_rigid_pose want;
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
            result_stall = 0;
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                results_seen++;
                if (expected_poses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t ns: result with nothing expected, actual rot %0d %0d %0d %0d",
                                 $time, result_bus.out_rot_x, result_bus.out_rot_y,
                                 result_bus.out_rot_z, result_bus.out_rot_w);
                end else begin
                    want = expected_poses.pop_front();
                    compare_field("out_rot_x", want.rot_x, result_bus.out_rot_x);
                    compare_field("out_rot_y", want.rot_y, result_bus.out_rot_y);
                    compare_field("out_rot_z", want.rot_z, result_bus.out_rot_z);
                    compare_field("out_rot_w", want.rot_w, result_bus.out_rot_w);
                    compare_field("out_shift_x", want.shift_x, result_bus.out_shift_x);
                    compare_field("out_shift_y", want.shift_y, result_bus.out_shift_y);
                    compare_field("out_shift_z", want.shift_z, result_bus.out_shift_z);
                end
                result_stall = $urandom_range(0, result_idle_max);
            end
            if (result_stall > 0) begin
                result_stall--;
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog: abort when no channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if ((child_bus.valid && child_bus.ready) || (result_bus.valid && result_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("rigid_transform_compose_top regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n                 = 1'b0;
        child_bus.valid         = 1'b0;
        child_bus.child_rot_x   = '0;
        child_bus.child_rot_y   = '0;
        child_bus.child_rot_z   = '0;
        child_bus.child_rot_w   = '0;
        child_bus.child_shift_x = '0;
        child_bus.child_shift_y = '0;
        child_bus.child_shift_z = '0;
        result_bus.ready        = 1'b0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.index           = '0;
        cfg_bus.data            = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Identity parent out of reset: children pass through.
        queue_child(make_pose(0, 0, 0, 0, 0, 0, 0));
        queue_child(make_pose(0, 0, 0, ROT_ONE, SHIFT_ONE, 2 * SHIFT_ONE, 3 * SHIFT_ONE));
        queue_child(make_pose(ROT_HI, ROT_HI, ROT_HI, ROT_HI, SHIFT_HI, SHIFT_HI, SHIFT_HI));
        queue_child(make_pose(ROT_LO, ROT_LO, ROT_LO, ROT_LO, SHIFT_LO, SHIFT_LO, SHIFT_LO));
        queue_child(make_pose(0, 0, 0, ROT_HI, SHIFT_LO, SHIFT_HI, -1));
        queue_child(make_pose(ROT_LO, ROT_HI, ROT_LO, ROT_HI, SHIFT_HI, SHIFT_LO, SHIFT_HI));
        queue_child(make_pose(0, 0, 0, ROT_LO, -SHIFT_ONE, 0, SHIFT_ONE));
        queue_child(make_pose(0, 0, 11585, 11585, SHIFT_ONE, 2 * SHIFT_ONE, 3 * SHIFT_ONE));
        wait_until_drained();

        // Largest non-unit parent, translation at the top rail.
        write_parent_set(ROT_HI, ROT_HI, ROT_HI, ROT_HI, SHIFT_HI, SHIFT_HI, SHIFT_HI);
        child_idle_max  = IDLE_MAX;
        queue_child(make_pose(0, 0, 0, 0, 0, 0, 0));
        queue_child(make_pose(ROT_HI, ROT_HI, ROT_HI, ROT_HI, SHIFT_HI, SHIFT_HI, SHIFT_HI));
        queue_child(make_pose(ROT_LO, ROT_LO, ROT_LO, ROT_LO, SHIFT_LO, SHIFT_LO, SHIFT_LO));
        queue_child(make_pose(ROT_LO, 0, ROT_HI, 0, SHIFT_HI, 0, SHIFT_LO));
        queue_child(make_pose(0, 0, 0, ROT_ONE, SHIFT_ONE, SHIFT_ONE, SHIFT_ONE));
        wait_until_drained();

        // Most negative parent, translation at the bottom rail.
        write_parent_set(ROT_LO, ROT_LO, ROT_LO, ROT_LO, SHIFT_LO, SHIFT_LO, SHIFT_LO);
        child_idle_max  = 0;
        result_idle_max = IDLE_MAX;
        queue_child(make_pose(0, 0, 0, 0, 0, 0, 0));
        queue_child(make_pose(ROT_HI, ROT_HI, ROT_HI, ROT_HI, SHIFT_HI, SHIFT_HI, SHIFT_HI));
        queue_child(make_pose(ROT_LO, ROT_LO, ROT_LO, ROT_LO, SHIFT_LO, SHIFT_LO, SHIFT_LO));
        queue_child(make_pose(ROT_HI, ROT_LO, 0, ROT_LO, SHIFT_LO, SHIFT_HI, 0));
        wait_until_drained();

        // Half-scale parent: rounding ties go toward plus infinity.
        write_parent_set(0, 0, 0, ROT_HALF, 0, 0, 0);
        child_idle_max  = IDLE_MAX;
        queue_child(make_pose(1, 0, 0, 0, 2, 0, 0));
        queue_child(make_pose(-1, 0, 0, 0, -2, 0, 0));
        queue_child(make_pose(0, 3, 0, -3, 6, -6, 2));
        queue_child(make_pose(0, 0, -1, 1, -6, 6, -2));
        wait_until_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            randomize_parent();
            case ($urandom_range(0, 3))
                0:       begin child_idle_max = 0;        result_idle_max = 0;        end
                1:       begin child_idle_max = IDLE_MAX; result_idle_max = 0;        end
                2:       begin child_idle_max = 0;        result_idle_max = IDLE_MAX; end
                default: begin child_idle_max = IDLE_MAX; result_idle_max = IDLE_MAX; end
            endcase
            repeat (ITEMS_PER_PHASE) queue_child(random_child());
            wait_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_poses.size() == 0) begin
            $display("rigid_transform_compose_top regression: pass");
        end else begin
            $display("rigid_transform_compose_top regression: fail");
        end
        $finish;
    end

endmodule
